@@ hdl/mvma_pkg.sv @@
// Shared types and constants for the matrix-vector multiply-accumulate core.
`timescale 1ns / 1ps
`default_nettype none

package mvma_pkg;

  localparam int IX_W        = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int SIZE_W      = 7;
  localparam int ACC_W       = 40;
  localparam int T_W         = 32;
  localparam int XW          = 66;

  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_COLS   = 64;
  localparam int DEF_DATA_WIDTH = 16;
  localparam int DEF_FRAC_BITS  = 12;

  localparam int SIZE_RESET  = 64;
  localparam int SCALE_RESET = 4096;

  typedef enum logic [1:0] {
    KIND_MATRIX,
    KIND_X,
    KIND_Y,
    KIND_START
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRANS_MODE,
    REG_ROWS_IN_USE,
    REG_COLS_IN_USE,
    REG_ALPHA,
    REG_BETA
  } reg_idx_t;

endpackage

`default_nettype wire

@@ hdl/matrix_vector_multiply_accumulate_core.sv @@
// Matrix-vector multiply-accumulate core: y := beta*y + alpha*op(A)*x.
//
//  channel  ports                                          direction
//  -------  ---------------------------------------------  ---------
//  in       in_valid in_stall in_kind in_row_index         input
//           in_col_index in_element_value
//  out      out_valid out_stall out_index out_value        output
//           out_last out_saturated
//  cfg      cfg_wr_en cfg_index cfg_wdata                  input
//
// A load item is accepted while the core is idle. A start item occupies the
// core until its last y element is out: the matrix memory read port yields
// one multiply-accumulate per cycle, then DRAIN, FIN1-FIN4 and EMIT finish
// each y element. A finished element held by out_stall keeps the core in EMIT.
// Input is stalled while a start is running. Reset clears control state only;
// the matrix, x and y memories hold nothing defined until written.
`timescale 1ns / 1ps
`default_nettype none

module matrix_vector_multiply_accumulate_core #(
  parameter int MAX_ROWS   = mvma_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = mvma_pkg::DEF_MAX_COLS,
  parameter int DATA_WIDTH = mvma_pkg::DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = mvma_pkg::DEF_FRAC_BITS
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [1:0]                       in_kind,
  input  wire  [mvma_pkg::IX_W-1:0]        in_row_index,
  input  wire  [mvma_pkg::IX_W-1:0]        in_col_index,
  input  wire  signed [DATA_WIDTH-1:0]     in_element_value,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [mvma_pkg::IX_W-1:0]        out_index,
  output logic signed [DATA_WIDTH-1:0]     out_value,
  output logic                             out_last,
  output logic                             out_saturated,
  input  wire                              cfg_wr_en,
  input  wire  [mvma_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [DATA_WIDTH-1:0]            cfg_wdata
);

  localparam int DW        = DATA_WIDTH;
  localparam int IXW       = mvma_pkg::IX_W;
  localparam int XW        = mvma_pkg::XW;
  localparam int TW        = mvma_pkg::T_W;
  localparam int ACCW      = mvma_pkg::ACC_W;
  localparam int VEC_DEPTH = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int VW        = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
  localparam int LW        = $clog2(VEC_DEPTH + 1);
  localparam int RXW       = (RW > IXW) ? RW : IXW;
  localparam int CXW       = (CW > IXW) ? CW : IXW;
  localparam int VXW       = (VW > IXW) ? VW : IXW;
  localparam int MAT_DEPTH = 2 ** (RW + CW);
  localparam int HSH       = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;

  localparam logic signed [XW-1:0] ACC_MAX = {{(XW-ACCW+1){1'b0}}, {(ACCW-1){1'b1}}};
  localparam logic signed [XW-1:0] ACC_MIN = ~ACC_MAX;
  localparam logic signed [XW-1:0] T_MAX   = {{(XW-TW+1){1'b0}}, {(TW-1){1'b1}}};
  localparam logic signed [XW-1:0] T_MIN   = ~T_MAX;
  localparam logic signed [XW-1:0] D_MAX   = {{(XW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [XW-1:0] D_MIN   = ~D_MAX;
  localparam logic signed [XW-1:0] SUM_LIM = XW'(1) << 62;
  localparam logic signed [XW-1:0] SUM_NEG = -SUM_LIM;
  localparam logic signed [XW-1:0] HALF    = (FRAC_BITS > 0) ? (XW'(1) << HSH) : '0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3,
    ST_FIN4,
    ST_EMIT
  } state_t;

  state_t                      state_r;
  logic                        trans_mode_r;
  logic [mvma_pkg::SIZE_W-1:0] rows_in_use_r;
  logic [mvma_pkg::SIZE_W-1:0] cols_in_use_r;
  logic signed [DW-1:0]        alpha_r;
  logic signed [DW-1:0]        beta_r;

  logic [LW-1:0]               leny_r;
  logic [LW-1:0]               lenk_r;
  logic [LW-1:0]               e_r;
  logic [LW-1:0]               k_r;
  logic                        v1_r;
  logic                        v2_r;
  logic signed [ACCW-1:0]      acc_r;
  logic                        sat_r;
  logic                        out_valid_r;
  logic [IXW-1:0]              out_index_r;
  logic signed [DW-1:0]        out_value_r;
  logic                        out_last_r;
  logic                        out_sat_r;

  logic signed [2*DW-1:0]      prod_r;
  logic signed [TW-1:0]        t_r;
  logic signed [DW+TW-1:0]     pa_r;
  logic signed [2*DW-1:0]      pb_r;
  logic signed [XW-1:0]        s_r;
  logic signed [DW-1:0]        res_r;

  logic signed [DW-1:0]        mat_mem [MAT_DEPTH];
  logic signed [DW-1:0]        x_mem [VEC_DEPTH];
  logic signed [DW-1:0]        y_mem [VEC_DEPTH];
  logic signed [DW-1:0]        a_q;
  logic signed [DW-1:0]        x_q;
  logic signed [DW-1:0]        y_q;

  logic                        in_acc;
  logic [RXW-1:0]              row_ext;
  logic [CXW-1:0]              col_ext;
  logic [VXW-1:0]              vec_ext;
  logic                        mat_wr;
  logic                        x_wr;
  logic                        y_load;
  logic                        out_free;
  logic                        emit_load;
  logic [RW+CW-1:0]            mat_rd_addr;
  logic [LW-1:0]               rows_cl;
  logic [LW-1:0]               cols_cl;

  logic signed [XW-1:0]        acc_sum;
  logic signed [ACCW-1:0]      acc_nxt;
  logic                        acc_clip;
  logic signed [XW-1:0]        t_rnd;
  logic signed [TW-1:0]        t_nxt;
  logic                        t_clip;
  logic signed [XW-1:0]        pa_c;
  logic signed [XW-1:0]        s_sum;
  logic signed [XW-1:0]        s_nxt;
  logic                        s_clip;
  logic signed [XW-1:0]        r_rnd;
  logic signed [DW-1:0]        r_nxt;
  logic                        r_clip;

  assign in_stall      = !rst_n || (state_r != ST_IDLE);
  assign in_acc        = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_index     = out_index_r;
  assign out_value     = out_value_r;
  assign out_last      = out_last_r;
  assign out_saturated = out_sat_r;

  assign row_ext  = RXW'(in_row_index);
  assign col_ext  = CXW'(in_col_index);
  assign vec_ext  = VXW'(in_row_index);
  assign mat_wr   = in_acc && (in_kind == mvma_pkg::KIND_MATRIX) &&
                    (int'(row_ext) < MAX_ROWS) && (int'(col_ext) < MAX_COLS);
  assign x_wr     = in_acc && (in_kind == mvma_pkg::KIND_X) && (int'(vec_ext) < VEC_DEPTH);
  assign y_load   = in_acc && (in_kind == mvma_pkg::KIND_Y) && (int'(vec_ext) < VEC_DEPTH);
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_load = (state_r == ST_EMIT) && out_free;

  assign mat_rd_addr = trans_mode_r ? {k_r[RW-1:0], e_r[CW-1:0]}
                                    : {e_r[RW-1:0], k_r[CW-1:0]};

  always_comb begin
    if (rows_in_use_r == '0) begin
      rows_cl = LW'(1);
    end else if (int'(rows_in_use_r) > MAX_ROWS) begin
      rows_cl = LW'(MAX_ROWS);
    end else begin
      rows_cl = LW'(rows_in_use_r);
    end
    if (cols_in_use_r == '0) begin
      cols_cl = LW'(1);
    end else if (int'(cols_in_use_r) > MAX_COLS) begin
      cols_cl = LW'(MAX_COLS);
    end else begin
      cols_cl = LW'(cols_in_use_r);
    end
  end

  always_comb begin
    acc_sum  = XW'(acc_r) + XW'(prod_r);
    acc_clip = 1'b0;
    if (acc_sum > ACC_MAX) begin
      acc_nxt  = ACCW'(ACC_MAX);
      acc_clip = 1'b1;
    end else if (acc_sum < ACC_MIN) begin
      acc_nxt  = ACCW'(ACC_MIN);
      acc_clip = 1'b1;
    end else begin
      acc_nxt  = ACCW'(acc_sum);
    end
  end

  always_comb begin
    if (FRAC_BITS == 0) begin
      t_rnd = XW'(acc_r);
    end else begin
      t_rnd = (XW'(acc_r) + HALF) >>> FRAC_BITS;
    end
    t_clip = 1'b0;
    if (t_rnd > T_MAX) begin
      t_nxt  = TW'(T_MAX);
      t_clip = 1'b1;
    end else if (t_rnd < T_MIN) begin
      t_nxt  = TW'(T_MIN);
      t_clip = 1'b1;
    end else begin
      t_nxt  = TW'(t_rnd);
    end
  end

  always_comb begin
    s_clip = 1'b0;
    if (XW'(pa_r) > SUM_LIM) begin
      pa_c   = SUM_LIM;
      s_clip = 1'b1;
    end else if (XW'(pa_r) < SUM_NEG) begin
      pa_c   = SUM_NEG;
      s_clip = 1'b1;
    end else begin
      pa_c   = XW'(pa_r);
    end
    s_sum = pa_c + XW'(pb_r);
    if (s_sum > SUM_LIM) begin
      s_nxt  = SUM_LIM;
      s_clip = 1'b1;
    end else if (s_sum < SUM_NEG) begin
      s_nxt  = SUM_NEG;
      s_clip = 1'b1;
    end else begin
      s_nxt  = s_sum;
    end
  end

  always_comb begin
    if (FRAC_BITS == 0) begin
      r_rnd = s_r;
    end else begin
      r_rnd = (s_r + HALF) >>> FRAC_BITS;
    end
    r_clip = 1'b0;
    if (r_rnd > D_MAX) begin
      r_nxt  = DW'(D_MAX);
      r_clip = 1'b1;
    end else if (r_rnd < D_MIN) begin
      r_nxt  = DW'(D_MIN);
      r_clip = 1'b1;
    end else begin
      r_nxt  = DW'(r_rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (mat_wr) begin
      mat_mem[{row_ext[RW-1:0], col_ext[CW-1:0]}] <= in_element_value;
    end
    a_q <= mat_mem[mat_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (x_wr) begin
      x_mem[vec_ext[VW-1:0]] <= in_element_value;
    end
    x_q <= x_mem[k_r[VW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (y_load) begin
      y_mem[vec_ext[VW-1:0]] <= in_element_value;
    end else if (emit_load) begin
      y_mem[e_r[VW-1:0]] <= res_r;
    end
    y_q <= y_mem[e_r[VW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      prod_r <= a_q * x_q;
    end
    if (state_r == ST_FIN1) begin
      t_r <= t_nxt;
    end
    if (state_r == ST_FIN2) begin
      pa_r <= alpha_r * t_r;
      pb_r <= beta_r * y_q;
    end
    if (state_r == ST_FIN3) begin
      s_r <= s_nxt;
    end
    if (state_r == ST_FIN4) begin
      res_r <= r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      trans_mode_r  <= 1'b0;
      rows_in_use_r <= mvma_pkg::SIZE_W'(mvma_pkg::SIZE_RESET);
      cols_in_use_r <= mvma_pkg::SIZE_W'(mvma_pkg::SIZE_RESET);
      alpha_r       <= DW'(mvma_pkg::SCALE_RESET);
      beta_r        <= DW'(mvma_pkg::SCALE_RESET);
      leny_r        <= '0;
      lenk_r        <= '0;
      e_r           <= '0;
      k_r           <= '0;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      acc_r         <= '0;
      sat_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          mvma_pkg::REG_TRANS_MODE:  trans_mode_r  <= cfg_wdata[0];
          mvma_pkg::REG_ROWS_IN_USE: rows_in_use_r <= cfg_wdata[mvma_pkg::SIZE_W-1:0];
          mvma_pkg::REG_COLS_IN_USE: cols_in_use_r <= cfg_wdata[mvma_pkg::SIZE_W-1:0];
          mvma_pkg::REG_ALPHA:       alpha_r       <= cfg_wdata;
          mvma_pkg::REG_BETA:        beta_r        <= cfg_wdata;
          default: ;
        endcase
      end

      v1_r <= (state_r == ST_MAC);
      v2_r <= v1_r;
      if (v2_r) begin
        acc_r <= acc_nxt;
        sat_r <= sat_r | acc_clip;
      end

      if (out_valid_r && !out_stall && !emit_load) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_kind == mvma_pkg::KIND_START)) begin
            leny_r  <= trans_mode_r ? cols_cl : rows_cl;
            lenk_r  <= trans_mode_r ? rows_cl : cols_cl;
            e_r     <= '0;
            k_r     <= '0;
            acc_r   <= '0;
            sat_r   <= 1'b0;
            state_r <= ST_MAC;
          end
        end
        ST_MAC: begin
          k_r <= k_r + LW'(1);
          if (k_r == lenk_r - LW'(1)) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!v1_r && !v2_r) begin
            state_r <= ST_FIN1;
          end
        end
        ST_FIN1: begin
          sat_r   <= sat_r | t_clip;
          state_r <= ST_FIN2;
        end
        ST_FIN2: begin
          state_r <= ST_FIN3;
        end
        ST_FIN3: begin
          sat_r   <= sat_r | s_clip;
          state_r <= ST_FIN4;
        end
        ST_FIN4: begin
          sat_r   <= sat_r | r_clip;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_index_r <= IXW'(e_r);
            out_value_r <= res_r;
            out_last_r  <= (e_r == leny_r - LW'(1));
            out_sat_r   <= sat_r;
            if (e_r == leny_r - LW'(1)) begin
              state_r <= ST_IDLE;
            end else begin
              e_r     <= e_r + LW'(1);
              k_r     <= '0;
              acc_r   <= '0;
              sat_r   <= 1'b0;
              state_r <= ST_MAC;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN1) |-> (!v1_r && !v2_r))
    else $error("accumulate pipeline not drained at finish");

  a_mac_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |-> ((k_r < lenk_r) && (e_r < leny_r)))
    else $error("matrix walk out of bounds");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_kind == mvma_pkg::KIND_START)) |=>
      ((state_r == ST_MAC) && (k_r == '0) && (e_r == '0) && (acc_r == '0)))
    else $error("start item did not begin a clean run");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_load && (e_r == leny_r - LW'(1))) |=> (out_valid_r && out_last_r && !in_stall))
    else $error("last element did not end the run");

endmodule

`default_nettype wire
